// File: sv/ktr_pkg.sv
// ktr_pkg: shared types and constants for the 4x4 kernel table resampler
// no dependencies
package ktr_pkg;

  localparam int TabPerPix   = 256;
  localparam int FracBits    = $clog2(TabPerPix);
  localparam int KernelDepth = 2 * TabPerPix + 1;
  localparam int KernelAw    = $clog2(KernelDepth);
  localparam int PixelDepth  = 65536;
  localparam int PixelAw     = $clog2(PixelDepth);
  localparam int QueueDepth  = 4;
  localparam int QueueAw     = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    REQ_KERNEL   = 2'd0,
    REQ_PIXEL    = 2'd1,
    REQ_RESAMPLE = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_ZERO    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ALPHA  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WTS, S_SUM, S_DEN, S_CHECK, S_RD, S_ROW, S_ACC, S_DSTART,
    S_DIV, S_NEXTCH, S_OUT
  } bstate_t;

  // front to back: one classified resample job
  typedef struct packed {
    logic                outside;
    logic [FracBits-1:0] tx;
    logic [FracBits-1:0] ty;
    logic [10:0]         px;
    logic [10:0]         py;
  } job_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [1:0]  status;
  } result_t;

endpackage

// File: sv/ktr_if.sv
// ktr_if: valid/ready channel interfaces for the resampler
// depends on ktr_pkg
interface ktr_in_if;
  import ktr_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] index;
  logic signed [15:0] kernel_value;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  logic signed [18:0] src_x;
  logic signed [18:0] src_y;
  modport source (output valid, req_type, index, kernel_value, red_in, green_in, blue_in,
                  alpha_in, src_x, src_y, input ready);
  modport sink (input valid, req_type, index, kernel_value, red_in, green_in, blue_in,
                alpha_in, src_x, src_y, output ready);
endinterface

interface ktr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;
  logic [1:0]  status;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, status,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, status,
                output ready);
endinterface

// File: sv/ktr_front.sv
// ktr_front: accepts beats, writes tables via ports, classifies resample points
// depends on ktr_pkg
module ktr_front import ktr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ktr_in_if.sink      in_ch,
  input  logic [10:0] padded_width,
  input  logic [10:0] padded_height,
  input  logic        q_full,
  input  logic        q_nempty,
  input  logic        back_busy,
  output logic        q_push,
  output job_t        q_job,
  output logic        kwr_en,
  output logic [KernelAw-1:0] kwr_addr,
  output logic [15:0] kwr_data,
  output logic        pwr_en,
  output logic [PixelAw-1:0] pwr_addr,
  output logic [63:0] pwr_data
);
  logic acc;
  logic is_load;
  logic [10:0] ix, iy;
  logic [11:0] limx, limy;

  // a load waits until every earlier point has finished reading the tables
  assign is_load     = req_t'(in_ch.req_type) inside {REQ_KERNEL, REQ_PIXEL};
  assign in_ch.ready = !q_full && !(is_load && (q_nempty || back_busy));
  assign acc = in_ch.valid && in_ch.ready;

  // table writes
  assign kwr_en   = acc && req_t'(in_ch.req_type) == REQ_KERNEL &&
                    {1'b0, in_ch.index} < 17'(KernelDepth);
  assign kwr_addr = in_ch.index[KernelAw-1:0];
  assign kwr_data = in_ch.kernel_value;
  assign pwr_en   = acc && req_t'(in_ch.req_type) == REQ_PIXEL &&
                    {1'b0, in_ch.index} < 17'(PixelDepth);
  assign pwr_addr = in_ch.index[PixelAw-1:0];
  assign pwr_data = {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  // classify point
  assign ix   = in_ch.src_x[18:FracBits];
  assign iy   = in_ch.src_y[18:FracBits];
  assign limx = {1'b0, padded_width} - 12'd3;
  assign limy = {1'b0, padded_height} - 12'd3;
  assign q_push = acc && req_t'(in_ch.req_type) == REQ_RESAMPLE;
  always_comb begin
    q_job.tx = in_ch.src_x[FracBits-1:0];
    q_job.ty = in_ch.src_y[FracBits-1:0];
    q_job.px = ix;
    q_job.py = iy;
    q_job.outside = in_ch.src_x[18] || in_ch.src_y[18] || ix == 11'd0 || iy == 11'd0 ||
                    padded_width < 11'd4 || padded_height < 11'd4 ||
                    {1'b0, ix} > limx || {1'b0, iy} > limy;
  end

  a_push_blocked: assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("push while queue full");
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    kwr_en || pwr_en |-> !q_nempty && !back_busy) else $error("load while points pending");
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !kwr_en && !pwr_en) else $error("push and load together");
endmodule

// File: sv/ktr_queue.sv
// ktr_queue: short job fifo between front and back
// depends on ktr_pkg
module ktr_queue import ktr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic nempty,
  output job_t dout
);
  job_t mem [QueueDepth];
  logic [QueueAw-1:0] wp, rp;
  logic [QueueAw:0] cnt;

  assign full   = cnt == (QueueAw+1)'(QueueDepth);
  assign nempty = cnt != '0;
  assign dout   = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst) !nempty |-> !pop)
    else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= (QueueAw+1)'(QueueDepth))
    else $error("queue count");
endmodule

// File: sv/ktr_div.sv
// ktr_div: restoring signed divider, one quotient bit a cycle, truncating
// depends on nothing
module ktr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] q, d, r;
  logic [64:0] trial;
  logic [6:0]  cnt;
  logic        busy, neg;

  assign trial = {r[63:0], q[63]} - {1'b0, d};
  assign quo = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        r    <= '0;
        q    <= num[63] ? 64'(-num) : 64'(num);
        d    <= den[63] ? 64'(-den) : 64'(den);
        neg  <= num[63] ^ den[63];
      end else if (busy) begin
        if (!trial[64]) begin
          r <= trial[63:0];
          q <= {q[62:0], 1'b1};
        end else begin
          r <= {r[62:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/ktr_back.sv
// ktr_back: holds the tables, runs the 4x4 weighted sum and division per job
// depends on ktr_pkg, ktr_div
module ktr_back import ktr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        alpha_enable,
  input  logic [10:0] padded_width,
  input  logic        kwr_en,
  input  logic [KernelAw-1:0] kwr_addr,
  input  logic [15:0] kwr_data,
  input  logic        pwr_en,
  input  logic [PixelAw-1:0] pwr_addr,
  input  logic [63:0] pwr_data,
  input  logic        q_nempty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        busy,
  ktr_out_if.source   out_ch
);
  logic [15:0] kmem [KernelDepth];
  logic [63:0] pmem [PixelDepth];
  logic [15:0] krd;
  logic [63:0] prd;
  logic [KernelAw-1:0] kaddr;
  logic [PixelAw-1:0] paddr;
  logic        pvalid, pvalid_r;

  bstate_t state, state_next;
  job_t    job;
  logic signed [15:0] w [8];
  logic [3:0]  wcnt;
  logic signed [17:0] sumx, sumy;
  logic signed [35:0] den;
  logic [1:0]  ch, r, c;
  logic signed [35:0] row;
  logic signed [63:0] acc;
  logic signed [35:0] wpix;
  logic signed [51:0] wrow;
  logic [15:0] res [4];
  logic        out_valid;
  logic        dstart, ddone;
  logic signed [63:0] dquo;
  logic [15:0] sat;
  logic signed [23:0] base_addr;
  logic [1:0]  ktap;
  logic [FracBits-1:0] kfrac;
  logic [15:0] pch;

  // memories
  always_ff @(posedge clk) begin
    if (kwr_en) kmem[kwr_addr] <= kwr_data;
    krd <= kmem[kaddr];
  end
  always_ff @(posedge clk) begin
    if (pwr_en) pmem[pwr_addr] <= pwr_data;
    prd <= pmem[paddr];
  end

  // kernel tap address: wcnt 0..3 x taps, 4..7 y taps
  assign ktap  = wcnt[1:0];
  assign kfrac = wcnt[2] ? job.ty : job.tx;
  always_comb begin
    case (ktap)
      2'd0:    kaddr = KernelAw'(TabPerPix) + KernelAw'(kfrac);
      2'd1:    kaddr = KernelAw'(kfrac);
      2'd2:    kaddr = KernelAw'(TabPerPix) - KernelAw'(kfrac);
      default: kaddr = KernelAw'(2 * TabPerPix) - KernelAw'(kfrac);
    endcase
  end

  // neighbour address
  logic signed [23:0] naddr;
  assign naddr = base_addr + $signed({22'd0, c}) - 24'sd1 +
                 ($signed({22'd0, r}) - 24'sd1) * $signed({13'd0, padded_width});
  assign pvalid = naddr >= 0 && naddr < 24'(PixelDepth);
  assign paddr  = naddr[PixelAw-1:0];
  assign pch    = pvalid_r ? prd[16*ch +: 16] : 16'd0;

  // tap products
  assign wpix = w[{1'b0, c}] * $signed({1'b0, pch});
  assign wrow = w[{1'b1, r}] * row;

  ktr_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(acc), .den(64'(den)),
                 .done(ddone), .quo(dquo));
  assign sat = dquo < 0 ? 16'd0 : (dquo > 65535 ? 16'hFFFF : dquo[15:0]);

  assign busy = state != S_IDLE;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    dstart = 1'b0;
    case (state)
      S_IDLE:   if (q_nempty && !out_valid) begin
        q_pop = 1'b1;
        state_next = S_WTS;
      end
      S_WTS:    if (job.outside) state_next = S_OUT;
                else if (wcnt == 4'd8) state_next = S_SUM;
      S_SUM:    state_next = S_DEN;
      S_DEN:    state_next = S_CHECK;
      S_CHECK:  state_next = (sumx == 18'sd0 || sumy == 18'sd0) ? S_OUT : S_RD;
      S_RD:     state_next = S_ROW;
      S_ROW:    state_next = c == 2'd3 ? S_ACC : S_RD;
      S_ACC:    state_next = r == 2'd3 ? S_DSTART : S_RD;
      S_DSTART: begin
        dstart = 1'b1;
        state_next = S_DIV;
      end
      S_DIV:    if (ddone) state_next = S_NEXTCH;
      S_NEXTCH: state_next = ch == 2'd3 ? S_OUT : S_RD;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    pvalid_r <= pvalid;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_nempty && !out_valid) begin
          job <= q_job; wcnt <= '0; ch <= '0; r <= '0; c <= '0;
          acc <= '0; row <= '0;
        end
        S_WTS: begin
          // read data comes back in the cycle after its address
          if (wcnt != 4'd0) w[wcnt[2:0] - 3'd1] <= krd;
          wcnt <= wcnt + 4'd1;
        end
        S_SUM: begin
          base_addr <= $signed({13'd0, job.px}) +
                       $signed({13'd0, job.py}) * $signed({13'd0, padded_width});
        end
        S_DEN: begin
          sumx <= 18'(w[0]) + 18'(w[1]) + 18'(w[2]) + 18'(w[3]);
          sumy <= 18'(w[4]) + 18'(w[5]) + 18'(w[6]) + 18'(w[7]);
        end
        S_CHECK: den <= sumx * sumy;
        S_ROW: begin
          row <= row + wpix;
          c <= c + 2'd1;
        end
        S_ACC: begin
          acc <= acc + 64'(wrow);
          row <= '0;
          r <= r + 2'd1;
        end
        S_DIV: if (ddone) begin
          res[ch] <= sat;
          acc <= '0;
        end
        S_NEXTCH: ch <= ch + 2'd1;
        S_OUT: begin
          out_valid <= 1'b1;
          if (job.outside) begin
            out_ch.status <= ST_OUTSIDE;
            out_ch.red_out <= '0; out_ch.green_out <= '0;
            out_ch.blue_out <= '0; out_ch.alpha_out <= '0;
          end else if (den == 0) begin
            out_ch.status <= ST_ZERO;
            out_ch.red_out <= '0; out_ch.green_out <= '0;
            out_ch.blue_out <= '0; out_ch.alpha_out <= '0;
          end else begin
            out_ch.status <= ST_OK;
            out_ch.red_out <= res[0]; out_ch.green_out <= res[1];
            out_ch.blue_out <= res[2];
            out_ch.alpha_out <= alpha_enable ? res[3] : 16'd0;
          end
        end
        default: ;
      endcase
    end
  end
  assign out_ch.valid = out_valid;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE && !out_valid) else $error("pop outside idle");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.status != ST_OK |-> out_ch.red_out == 16'd0)
    else $error("nonzero value with error status");
endmodule

// File: sv/kernel_table_resampler_4x4.sv
// kernel_table_resampler_4x4: top level of the 4x4 tabulated kernel resampler
// depends on ktr_pkg, ktr_if, ktr_front, ktr_queue, ktr_back
//
// Usage: beats on in_ch either load a kernel entry (req_type 0), load a
// padded source pixel (1) or request a resample point (2); type 3 is dropped.
// A load beat is held off until every earlier point has finished, then it
// takes effect in the cycle it is accepted and gives no result.
// Each resample beat gives one result beat on out_ch with status 0 ok,
// 1 outside bounds, 2 zero weight sum.
// The front accepts a point each cycle while the four-entry job queue has room.
// The back handles one point at a time: eight kernel reads, the base address, the
// weight sums and their product, then per channel 16 neighbour reads (a read and an
// accumulate state each, single pixel memory port), 4 row steps and a 64-step
// bit-serial divide. An outside point goes to its result straight after the pop
// and a zero weight sum skips the neighbour reads and the divides.
// Reset clears control state only; table contents are undefined until loaded
// and config returns to width 256, height 256, alpha on. A stalled receiver
// holds the result register; jobs then queue up and the input stalls once the
// queue is full. The user writes config only while idle; it is not enforced.
module kernel_table_resampler_4x4 import ktr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ktr_in_if.sink      in_ch,
  ktr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  logic [10:0] padded_width, padded_height;
  logic        alpha_enable;
  logic        q_full, q_push, q_pop, q_nempty;
  logic        back_busy;
  job_t        q_in, q_out;
  logic        kwr_en, pwr_en;
  logic [KernelAw-1:0] kwr_addr;
  logic [PixelAw-1:0]  pwr_addr;
  logic [15:0] kwr_data;
  logic [63:0] pwr_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width <= 11'd256; padded_height <= 11'd256; alpha_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  padded_width <= cfg_data;
        CFG_HEIGHT: padded_height <= cfg_data;
        CFG_ALPHA:  alpha_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ktr_front u_front (.clk(clk), .rst(rst), .in_ch(in_ch), .padded_width(padded_width),
    .padded_height(padded_height), .q_full(q_full), .q_nempty(q_nempty),
    .back_busy(back_busy), .q_push(q_push), .q_job(q_in),
    .kwr_en(kwr_en), .kwr_addr(kwr_addr), .kwr_data(kwr_data),
    .pwr_en(pwr_en), .pwr_addr(pwr_addr), .pwr_data(pwr_data));

  ktr_queue u_queue (.clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .nempty(q_nempty), .dout(q_out));

  ktr_back u_back (.clk(clk), .rst(rst), .alpha_enable(alpha_enable),
    .padded_width(padded_width), .kwr_en(kwr_en), .kwr_addr(kwr_addr),
    .kwr_data(kwr_data), .pwr_en(pwr_en), .pwr_addr(pwr_addr), .pwr_data(pwr_data),
    .q_nempty(q_nempty), .q_job(q_out), .q_pop(q_pop), .busy(back_busy),
    .out_ch(out_ch));
endmodule
